FILE: hw/rtl/cmta_pkg.sv
package cmta_pkg;

    // Fixed field widths
    localparam int DIR_W  = 16;
    localparam int CFG_W  = 13;
    localparam int LOC_W  = DIR_W + 1;   // face-local component, signed
    localparam int MAG_W  = DIR_W;       // major magnitude, at most 2^15
    localparam int DEN_W  = DIR_W + 1;   // twice the major magnitude
    localparam int REM_W  = DIR_W;       // divider remainder, always below DEN

    // Face size after reset
    localparam logic [CFG_W-1:0] FACE_SIZE_RESET = 13'd256;

    // Cube face codes
    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // Control that travels with each item
    typedef struct packed {
        t_face face;
        logic  zero;
    } t_ctrl;

endpackage

FILE: hw/rtl/cube_map_texel_address_unit.sv
// From input transfer to o_valid: stages 1 to 3, the divider stages, then the output register.
// Throughput: one direction per cycle while not stalled; the divider is one restoring stage per quotient bit.
// A stall at the output holds every stage at once; o_stall follows i_stall while o_valid is high.
// Reset (synchronous, active low) clears all valid bits and sets the face size to 256.
// Configuration takes effect on the next transfer; write it only while the pipeline is empty.
module cube_map_texel_address_unit
    import cmta_pkg::*;
#(
    parameter int MAX_FACE_SIZE = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_face_size_we,
    input  logic [CFG_W-1:0]                       i_face_size,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [DIR_W-1:0]                i_dir_x,
    input  logic signed [DIR_W-1:0]                i_dir_y,
    input  logic signed [DIR_W-1:0]                i_dir_z,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [2:0]                             o_face,
    output logic [$clog2(MAX_FACE_SIZE)-1:0]       o_coord_u,
    output logic [$clog2(MAX_FACE_SIZE)-1:0]       o_coord_v,
    output logic [2*$clog2(MAX_FACE_SIZE)-1:0]     o_texel_offset,
    output logic                                   o_zero_vector
);

    localparam int CW = $clog2(MAX_FACE_SIZE);       // coordinate width
    localparam int SW = $clog2(MAX_FACE_SIZE + 1);   // face size width
    localparam int OW = 2 * CW;                      // offset width
    localparam int NW = REM_W + CW;                  // dividend width

    // Face size register and its clamped forms
    logic [CFG_W-1:0] r_face_size;
    logic [SW-1:0]    s_eff;
    logic [CW-1:0]    s_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= FACE_SIZE_RESET;
        end else if (i_face_size_we) begin
            r_face_size <= i_face_size;
        end
    end

    always_comb begin
        if (32'(r_face_size) > 32'(MAX_FACE_SIZE)) begin
            s_eff = SW'(MAX_FACE_SIZE);
        end else if (r_face_size == '0) begin
            s_eff = SW'(1);
        end else begin
            s_eff = SW'(r_face_size);
        end
        s_m1 = CW'(s_eff - SW'(1));
    end

    // Global advance: the whole pipeline moves unless the output transfer is blocked
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: magnitudes, major axis, face-local components
    logic signed [LOC_W-1:0] x17, y17, z17;
    logic [LOC_W-1:0]        ax, ay, az;
    logic signed [LOC_W-1:0] n_u1, n_v1;
    logic [MAG_W-1:0]        n_m1;
    t_ctrl                   n_c1;

    always_comb begin
        x17 = LOC_W'(i_dir_x);
        y17 = LOC_W'(i_dir_y);
        z17 = LOC_W'(i_dir_z);
        ax  = x17[LOC_W-1] ? LOC_W'(-x17) : x17;
        ay  = y17[LOC_W-1] ? LOC_W'(-y17) : y17;
        az  = z17[LOC_W-1] ? LOC_W'(-z17) : z17;
        n_c1.zero = (ax == '0) && (ay == '0) && (az == '0);
        if (az >= ax && az >= ay) begin
            n_m1      = MAG_W'(az);
            n_u1      = (z17 > 0) ? x17 : LOC_W'(-x17);
            n_v1      = y17;
            n_c1.face = (z17 > 0) ? FACE_POS_Z : FACE_NEG_Z;
        end else if (ay >= ax) begin
            n_m1      = MAG_W'(ay);
            n_u1      = x17;
            n_v1      = (y17 > 0) ? LOC_W'(-z17) : z17;
            n_c1.face = (y17 > 0) ? FACE_POS_Y : FACE_NEG_Y;
        end else begin
            n_m1      = MAG_W'(ax);
            n_u1      = (x17 > 0) ? LOC_W'(-z17) : z17;
            n_v1      = y17;
            n_c1.face = (x17 > 0) ? FACE_POS_X : FACE_NEG_X;
        end
    end

    logic                    r_v1;
    logic signed [LOC_W-1:0] r_u1, r_v1c;
    logic [MAG_W-1:0]        r_m1;
    t_ctrl                   r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u1  <= n_u1;
            r_v1c <= n_v1;
            r_m1  <= n_m1;
            r_c1  <= n_c1;
        end
    end

    // Stage 2: shift into [0, 2m] and form the divisor 2m
    logic [LOC_W-1:0] n_tu2, n_tv2;
    logic [DEN_W-1:0] n_den2;

    assign n_tu2  = LOC_W'(r_u1)  + LOC_W'(r_m1);
    assign n_tv2  = LOC_W'(r_v1c) + LOC_W'(r_m1);
    assign n_den2 = {r_m1, 1'b0};

    logic             r_v2;
    logic [LOC_W-1:0] r_tu2, r_tv2;
    logic [DEN_W-1:0] r_den2;
    t_ctrl            r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tu2  <= n_tu2;
            r_tv2  <= n_tv2;
            r_den2 <= n_den2;
            r_c2   <= r_c1;
        end
    end

    // Stage 3: scale by (size - 1); the product always fits NW bits
    logic [NW-1:0] n_nu3, n_nv3;

    assign n_nu3 = NW'(r_tu2 * s_m1);
    assign n_nv3 = NW'(r_tv2 * s_m1);

    logic             r_v3;
    logic [NW-1:0]    r_nu3, r_nv3;
    logic [DEN_W-1:0] r_den3;
    t_ctrl            r_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nu3  <= n_nu3;
            r_nv3  <= n_nv3;
            r_den3 <= r_den2;
            r_c3   <= r_c2;
        end
    end

    // Divider: one restoring step per stage, quotient bits shift into the low word
    logic             r_dv   [CW];
    logic [REM_W-1:0] r_rem_u[CW];
    logic [REM_W-1:0] r_rem_v[CW];
    logic [CW-1:0]    r_lo_u [CW];
    logic [CW-1:0]    r_lo_v [CW];
    logic [DEN_W-1:0] r_den  [CW];
    t_ctrl            r_dc   [CW];

    for (genvar k = 0; k < CW; k++) begin : g_div
        logic             src_v;
        logic [REM_W-1:0] src_rem_u, src_rem_v;
        logic [CW-1:0]    src_lo_u, src_lo_v;
        logic [DEN_W-1:0] src_den;
        t_ctrl            src_c;
        logic [DEN_W-1:0] sh_u, sh_v;
        logic             q_u, q_v;
        logic [REM_W-1:0] n_rem_u, n_rem_v;
        logic [CW-1:0]    n_lo_u, n_lo_v;

        if (k == 0) begin : g_first
            assign src_v     = r_v3;
            assign src_rem_u = r_nu3[NW-1:CW];
            assign src_rem_v = r_nv3[NW-1:CW];
            assign src_lo_u  = r_nu3[CW-1:0];
            assign src_lo_v  = r_nv3[CW-1:0];
            assign src_den   = r_den3;
            assign src_c     = r_c3;
        end else begin : g_next
            assign src_v     = r_dv[k-1];
            assign src_rem_u = r_rem_u[k-1];
            assign src_rem_v = r_rem_v[k-1];
            assign src_lo_u  = r_lo_u[k-1];
            assign src_lo_v  = r_lo_v[k-1];
            assign src_den   = r_den[k-1];
            assign src_c     = r_dc[k-1];
        end

        // Trial subtract on both lanes
        always_comb begin
            sh_u    = {src_rem_u, src_lo_u[CW-1]};
            sh_v    = {src_rem_v, src_lo_v[CW-1]};
            q_u     = (sh_u >= src_den);
            q_v     = (sh_v >= src_den);
            n_rem_u = q_u ? REM_W'(sh_u - src_den) : REM_W'(sh_u);
            n_rem_v = q_v ? REM_W'(sh_v - src_den) : REM_W'(sh_v);
            n_lo_u  = CW'({src_lo_u, q_u});
            n_lo_v  = CW'({src_lo_v, q_v});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (en) begin
                r_dv[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem_u[k] <= n_rem_u;
                r_rem_v[k] <= n_rem_v;
                r_lo_u[k]  <= n_lo_u;
                r_lo_v[k]  <= n_lo_v;
                r_den[k]   <= src_den;
                r_dc[k]    <= src_c;
            end
        end
    end

    // Output stage: row-major offset, zero vector forces all fields to zero
    logic [CW-1:0] cu, cv;
    logic [OW-1:0] n_off;
    t_ctrl         dc_last;

    assign cu      = r_lo_u[CW-1];
    assign cv      = r_lo_v[CW-1];
    assign dc_last = r_dc[CW-1];
    assign n_off   = OW'(cv * s_eff + cu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dv[CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_zero_vector <= dc_last.zero;
            if (dc_last.zero) begin
                o_face         <= FACE_POS_X;
                o_coord_u      <= '0;
                o_coord_v      <= '0;
                o_texel_offset <= '0;
            end else begin
                o_face         <= dc_last.face;
                o_coord_u      <= cu;
                o_coord_v      <= cv;
                o_texel_offset <= n_off;
            end
        end
    end

    // Checks
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |-> (o_coord_u == '0 && o_coord_v == '0 &&
                                        o_texel_offset == '0 && o_face == FACE_POS_X))
        else $error("zero vector result carries nonzero fields");

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_zero_vector) |-> (SW'(o_coord_u) < s_eff && SW'(o_coord_v) < s_eff))
        else $error("texel coordinate beyond face size");

    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_zero_vector) |-> (o_texel_offset == OW'(o_coord_v * s_eff + o_coord_u)))
        else $error("texel offset does not match coordinates");

endmodule

FILE: test/tb_cube_map_texel_address_unit.sv
module tb_cube_map_texel_address_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cmta_pkg::*;

    localparam int MAX_FACE_SIZE = 4096;
    localparam int CW            = $clog2(MAX_FACE_SIZE);
    localparam int RUN_LIMIT     = 200000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 95;

    // One expected texel address
    typedef struct {
        t_face           face;
        logic [CW-1:0]   coord_u;
        logic [CW-1:0]   coord_v;
        logic [2*CW-1:0] offset;
        logic            zero;
    } t_texel;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_face_size_we = 1'b0;
    logic [CFG_W-1:0]        i_face_size    = '0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic signed [DIR_W-1:0] i_dir_x        = '0;
    logic signed [DIR_W-1:0] i_dir_y        = '0;
    logic signed [DIR_W-1:0] i_dir_z        = '0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic [2:0]              o_face;
    logic [CW-1:0]           o_coord_u;
    logic [CW-1:0]           o_coord_v;
    logic [2*CW-1:0]         o_texel_offset;
    logic                    o_zero_vector;

    t_texel           pending_texels[$];
    t_texel           want;
    logic [CFG_W-1:0] face_size_model = FACE_SIZE_RESET;
    int               gap_pct         = 0;
    int               stall_pct       = 0;
    int               err_count       = 0;
    int               dirs_sent       = 0;
    int               zero_dirs       = 0;
    int               cfg_writes      = 0;
    int               cycle_count     = 0;

    cube_map_texel_address_unit #(
        .MAX_FACE_SIZE(MAX_FACE_SIZE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_face_size_we(i_face_size_we),
        .i_face_size   (i_face_size),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_face        (o_face),
        .o_coord_u     (o_coord_u),
        .o_coord_v     (o_coord_v),
        .o_texel_offset(o_texel_offset),
        .o_zero_vector (o_zero_vector)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Map a face-local component from [-m,m] onto [0,s-1], truncating
    function automatic longint unsigned scale_axis(input int c, input int m,
                                                   input longint unsigned s);
        longint unsigned num;
        longint unsigned den;
        num = longint'(c + m) * (s - 1);
        den = longint'(2 * m);
        return num / den;
    endfunction

    // Face select, face-local axes with sign flips, then scale to texels
    function automatic t_texel predict_texel(input logic signed [DIR_W-1:0] x, y, z,
                                             input logic [CFG_W-1:0] size_reg);
        int              sx, sy, sz, ax, ay, az, mj, lu, lv;
        longint unsigned s, cu, cv, lin;
        t_texel          t;
        sx = int'(x);
        sy = int'(y);
        sz = int'(z);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        t.face    = FACE_POS_X;
        t.coord_u = '0;
        t.coord_v = '0;
        t.offset  = '0;
        t.zero    = 1'b0;
        if (ax == 0 && ay == 0 && az == 0) begin
            t.zero = 1'b1;
            return t;
        end
        // Z beats Y beats X on equal magnitude
        if (az >= ax && az >= ay) begin
            mj     = az;
            lu     = (sz > 0) ? sx : -sx;
            lv     = sy;
            t.face = (sz > 0) ? FACE_POS_Z : FACE_NEG_Z;
        end else if (ay >= ax) begin
            mj     = ay;
            lu     = sx;
            lv     = (sy > 0) ? -sz : sz;
            t.face = (sy > 0) ? FACE_POS_Y : FACE_NEG_Y;
        end else begin
            mj     = ax;
            lu     = (sx > 0) ? -sz : sz;
            lv     = sy;
            t.face = (sx > 0) ? FACE_POS_X : FACE_NEG_X;
        end
        // Clamp the register to the supported range
        s = 64'(size_reg);
        if (s == 0) s = 1;
        if (s > MAX_FACE_SIZE) s = MAX_FACE_SIZE;
        cu  = scale_axis(lu, mj, s);
        cv  = scale_axis(lv, mj, s);
        lin = cv * s + cu;
        t.coord_u = cu[CW-1:0];
        t.coord_v = cv[CW-1:0];
        t.offset  = lin[2*CW-1:0];
        return t;
    endfunction

    // Receiver side: random stall
    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Run limit of %0d cycles reached, %0d results outstanding",
                     RUN_LIMIT, pending_texels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            pending_texels.push_back(predict_texel(i_dir_x, i_dir_y, i_dir_z,
                                                   face_size_model));
            dirs_sent++;
            if (i_dir_x == 0 && i_dir_y == 0 && i_dir_z == 0) zero_dirs++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_texels.size() == 0) begin
                $error("unexpected result: face %0d u %0d v %0d offset %0d zero %0d",
                       o_face, o_coord_u, o_coord_v, o_texel_offset, o_zero_vector);
                err_count++;
            end else begin
                want = pending_texels.pop_front();
                if (o_face !== want.face) begin
                    $error("face: expected %0d, got %0d", want.face, o_face);
                    err_count++;
                end
                if (o_coord_u !== want.coord_u) begin
                    $error("coord_u: expected %0d, got %0d", want.coord_u, o_coord_u);
                    err_count++;
                end
                if (o_coord_v !== want.coord_v) begin
                    $error("coord_v: expected %0d, got %0d", want.coord_v, o_coord_v);
                    err_count++;
                end
                if (o_texel_offset !== want.offset) begin
                    $error("texel_offset: expected %0d, got %0d", want.offset,
                           o_texel_offset);
                    err_count++;
                end
                if (o_zero_vector !== want.zero) begin
                    $error("zero_vector: expected %0d, got %0d", want.zero, o_zero_vector);
                    err_count++;
                end
            end
        end
    end

    // Present one direction, optionally after a random gap, and hold until transfer
    task automatic send_direction(input logic signed [DIR_W-1:0] x, y, z);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid <= 1'b1;
        i_dir_x <= x;
        i_dir_y <= y;
        i_dir_z <= z;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait for every pending result
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_texels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_face_size(input logic [CFG_W-1:0] size);
        drain_pipeline();
        i_face_size_we  <= 1'b1;
        i_face_size     <= size;
        face_size_model  = size;
        @(posedge i_clk);
        i_face_size_we  <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [CFG_W-1:0] pick_face_size();
        case ($urandom_range(6))
            0:       return 13'd1;
            1:       return 13'd4096;
            2:       return FACE_SIZE_RESET;
            3:       return 13'd8191;
            4:       return 13'($urandom_range(2, 64));
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    // Mix of full-range, small, tied, extreme and near-axis directions
    task automatic random_direction(output logic signed [DIR_W-1:0] x, y, z);
        int kind;
        kind = $urandom_range(9);
        x = DIR_W'($urandom);
        y = DIR_W'($urandom);
        z = DIR_W'($urandom);
        case (kind)
            5: begin
                x = DIR_W'($signed($urandom_range(16)) - 8);
                y = DIR_W'($signed($urandom_range(16)) - 8);
                z = DIR_W'($signed($urandom_range(16)) - 8);
            end
            6: begin
                // Equal magnitudes with random signs, sometimes one axis left free
                y = $urandom_range(1) ? x : -x;
                z = $urandom_range(1) ? x : -x;
                case ($urandom_range(3))
                    0:       x = DIR_W'($urandom);
                    1:       y = DIR_W'($urandom);
                    2:       z = DIR_W'($urandom);
                    default: ;
                endcase
            end
            7: begin
                case ($urandom_range(2))
                    0:       x = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
                    1:       y = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
                    default: z = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
                endcase
            end
            8: begin
                if ($urandom_range(3) == 0) begin
                    x = '0;
                    y = '0;
                    z = '0;
                end else begin
                    x = DIR_W'($signed($urandom_range(64)) - 32);
                    y = DIR_W'($signed($urandom_range(64)) - 32);
                end
            end
            default: ;
        endcase
    endtask

    // Every face, ties, most negative components and the zero vector
    task automatic test_directed_faces();
        set_face_size(FACE_SIZE_RESET);
        send_direction(16'sd0, 16'sd0, 16'sd0);
        send_direction(16'sh7fff, 16'sd0, 16'sd0);
        send_direction(16'sh8000, 16'sd0, 16'sd0);
        send_direction(16'sd0, 16'sh7fff, 16'sd0);
        send_direction(16'sd0, 16'sh8000, 16'sd0);
        send_direction(16'sd0, 16'sd0, 16'sh7fff);
        send_direction(16'sd0, 16'sd0, 16'sh8000);
        send_direction(16'sd100, 16'sd100, 16'sd100);
        send_direction(16'sh8000, 16'sh8000, 16'sh8000);
        send_direction(16'sd500, -16'sd500, 16'sd10);
        send_direction(-16'sd300, 16'sd5, 16'sd300);
        send_direction(-16'sd1, -16'sd1, 16'sd0);
        send_direction(16'sd1, 16'sd0, 16'sd0);
        send_direction(16'sd0, 16'sd0, -16'sd1);
        send_direction(16'sh8000, 16'sh7fff, 16'sd0);
        send_direction(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_direction(16'sh7fff, 16'sh8000, 16'sh8000);
    endtask

    // Zero, smallest, largest and saturating face sizes
    task automatic test_face_size_extremes();
        logic [CFG_W-1:0] sizes[6];
        sizes = '{13'd0, 13'd1, 13'd2, 13'd4096, 13'd4097, 13'd8191};
        foreach (sizes[k]) begin
            set_face_size(sizes[k]);
            send_direction(16'sh7fff, 16'sh8000, 16'sd0);
            send_direction(16'sh8000, 16'sd1, -16'sd32767);
        end
    endtask

    // Random directions under three idle mixes, new face size per chunk
    task automatic test_random_directions();
        logic signed [DIR_W-1:0] x, y, z;
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct   = (phase == 0) ? 19 : (phase == 1) ? 57 : 0;
            stall_pct = (phase == 0) ? 57 : (phase == 1) ? 19 : 0;
            for (int chunk = 0; chunk < 3; chunk++) begin
                set_face_size(pick_face_size());
                repeat (PHASE_ITEMS) begin
                    random_direction(x, y, z);
                    send_direction(x, y, z);
                end
            end
        end
    endtask

    initial begin
        gap_pct   = 19;
        stall_pct = 57;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_faces();
        test_face_size_extremes();
        test_random_directions();
        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d directions, %0d of them zero, over %0d face size writes",
                 dirs_sent, zero_dirs, cfg_writes);
        $display("Idle mixes: sender 19%%/receiver 57%%, then 57%%/19%%, then none");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
